// ===== hdl/rbts_pkg.sv =====
// rbts_pkg: shared types and constants for the radio bring-up / transmit sequencer.
// No dependencies; used by radio_bringup_tx_sequencer_core.
`default_nettype none

package rbts_pkg;

   localparam int unsigned REQ_DATA_W = 208;
   localparam int unsigned RSP_DATA_W = 96;
   localparam int unsigned ACTION_W   = 2;

   typedef enum logic [1:0] {
      ACT_RESET    = 2'd0,
      ACT_POLL     = 2'd1,
      ACT_SCHEDULE = 2'd2,
      ACT_CANCEL   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      MODE_INVALID   = 4'd0,
      MODE_RST       = 4'd1,
      MODE_WAIT_IRQ  = 4'd2,
      MODE_WAIT_PLL  = 4'd3,
      MODE_CALIB     = 4'd4,
      MODE_READY     = 4'd5,
      MODE_TX_WAIT   = 4'd8,
      MODE_TX_ACTIVE = 4'd9,
      MODE_TX_LATE   = 4'd10,
      MODE_CHIP_ERR  = 4'd11,
      MODE_BUG       = 4'd12
   } mode_type;

   typedef enum logic [3:0] {
      ERR_NONE      = 4'd0,
      ERR_GENERIC   = 4'd1,
      ERR_IMPULSE   = 4'd2,
      ERR_LOW_VOLT  = 4'd3,
      ERR_PLL       = 4'd4,
      ERR_COMMAND   = 4'd5,
      ERR_SPI       = 4'd6,
      ERR_BAD_SIZE  = 4'd7,
      ERR_NOT_READY = 4'd8
   } err_type;

   typedef enum logic [1:0] {
      DRV_NONE    = 2'd0,
      DRV_LOW     = 2'd1,
      DRV_RELEASE = 2'd2
   } drive_type;

   typedef enum logic [1:0] {
      CALW_NONE  = 2'd0,
      CALW_START = 2'd1,
      CALW_STOP  = 2'd2
   } calw_type;

   typedef enum logic [1:0] {
      CMD_NONE     = 2'd0,
      CMD_DELAY_TX = 2'd1,
      CMD_TRX_OFF  = 2'd2
   } cmd_type;

   localparam logic [31:0] ERR_LO_MASK     = 32'h020C_0000;
   localparam logic [31:0] ERR_HI_MASK     = 32'h0000_0F00;
   localparam logic [31:0] IMPULSE_BIT     = 32'h0004_0000;
   localparam logic [31:0] LOW_VOLT_BIT    = 32'h0008_0000;
   localparam logic [31:0] PLL_ERR_BIT     = 32'h0200_0000;
   localparam logic [31:0] CMD_ERR_HI_BIT  = 32'h0000_0100;
   localparam logic [31:0] SPI_ERR_HI_MASK = 32'h0000_0E00;
   localparam logic [31:0] PLL_LOCK_BIT    = 32'h0000_0002;
   localparam logic [31:0] TX_START_MASK   = 32'h0000_00F0;
   localparam logic [31:0] TX_LATE_BIT     = 32'h0800_0000;
   localparam logic [31:0] TX_DONE_BIT     = 32'h0000_0080;
   localparam logic [31:0] RSTATE_IDLE     = 32'h000D_0000;
   localparam logic [12:0] FCTL_BASE       = 13'h1C00;
   localparam logic [9:0]  FRAME_SIZE_MAX  = 10'd1021;
   localparam logic [7:0]  HOLD_MS_RESET   = 8'd10;

   typedef struct packed {
      logic [31:0] stime;
      logic [12:0] fctl;
      cmd_type     cmd;
      logic [31:0] clr;
      calw_type    calw;
      logic        setup;
      drive_type   drv;
      err_type     cause;
      mode_type    mode;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/radio_bringup_tx_sequencer_core.sv =====
// Radio bring-up and delayed-transmit sequencer, single module.
// Registers: a req is staged in s1, then moves to the rsp register once that is free or taken.
// Throughput: one transfer per cycle; a stalled rsp holds while one more req is staged.
// Reset: synchronous, active high; clears mode, reset stamp, error cause, valids;
// hold time returns to 10 ms. csr writes always accepted.
// Depends on rbts_pkg.
`default_nettype none

module radio_bringup_tx_sequencer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [7:0]                       csr_data,   // reset_hold_ms
   // requests
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // now_ms, irq_level, status_low, status_high, calibration_status,
   // radio_state, frame_size, transmit_time, zero pad
   input  wire logic [rbts_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [rbts_pkg::ACTION_W-1:0]    req_tuser,  // action
   // results
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // status, error_kind, drive_reset, chip_setup, calibration_write,
   // clear_mask, radio_command, frame_control, scheduled_time, zero pad
   output logic [rbts_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   logic                                 s1_valid_ff, s1_valid_in;
   logic [rbts_pkg::REQ_DATA_W-1:0]      s1_data_ff;
   logic [rbts_pkg::ACTION_W-1:0]        s1_act_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   rbts_pkg::rsp_type                    rsp_ff, rsp_in;
   rbts_pkg::mode_type                   mode_ff, mode_in;
   rbts_pkg::err_type                    cause_ff, cause_in;
   logic [31:0]                          stamp_ff, stamp_in;
   logic [7:0]                           hold_ff;
   logic                                 advance;

   logic [31:0] now_ms, status_low, status_high, cal_status, radio_state, transmit_time;
   logic [31:0] elapsed;
   logic [9:0]  frame_size;
   logic        irq_level;
   rbts_pkg::action_type action;

   assign now_ms        = s1_data_ff[31:0];
   assign irq_level     = s1_data_ff[32];
   assign status_low    = s1_data_ff[64:33];
   assign status_high   = s1_data_ff[96:65];
   assign cal_status    = s1_data_ff[128:97];
   assign radio_state   = s1_data_ff[160:129];
   assign frame_size    = s1_data_ff[170:161];
   assign transmit_time = s1_data_ff[202:171];
   assign action        = rbts_pkg::action_type'(s1_act_ff);
   assign elapsed       = now_ms - stamp_ff;

   assign advance      = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !s1_valid_ff || advance;
   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   assign csr_ready    = 1'b1;

   always_comb begin
      logic stop;
      stop     = 1'b0;
      mode_in  = mode_ff;
      cause_in = cause_ff;
      stamp_in = stamp_ff;
      rsp_in   = '0;
      unique case (action)
         rbts_pkg::ACT_RESET: begin
            rsp_in.drv = rbts_pkg::DRV_LOW;
            mode_in    = rbts_pkg::MODE_RST;
            stamp_in   = now_ms;
         end
         rbts_pkg::ACT_POLL: begin
            if (mode_in == rbts_pkg::MODE_RST) begin
               if (elapsed < {24'd0, hold_ff} || irq_level) begin
                  stop = 1'b1;
               end else begin
                  rsp_in.drv = rbts_pkg::DRV_RELEASE;
                  mode_in    = rbts_pkg::MODE_WAIT_IRQ;
               end
            end
            if (!stop && mode_in == rbts_pkg::MODE_WAIT_IRQ) begin
               if (!irq_level) begin
                  stop = 1'b1;
               end else begin
                  rsp_in.setup = 1'b1;
                  mode_in      = rbts_pkg::MODE_WAIT_PLL;
               end
            end
            if (!stop) begin
               if ((status_low & rbts_pkg::ERR_LO_MASK) != '0 ||
                   (status_high & rbts_pkg::ERR_HI_MASK) != '0) begin
                  mode_in = rbts_pkg::MODE_CHIP_ERR;
                  priority if ((status_high & rbts_pkg::SPI_ERR_HI_MASK) != '0) begin
                     cause_in = rbts_pkg::ERR_SPI;
                  end else if ((status_high & rbts_pkg::CMD_ERR_HI_BIT) != '0) begin
                     cause_in = rbts_pkg::ERR_COMMAND;
                  end else if ((status_low & rbts_pkg::PLL_ERR_BIT) != '0) begin
                     cause_in = rbts_pkg::ERR_PLL;
                  end else if ((status_low & rbts_pkg::LOW_VOLT_BIT) != '0) begin
                     cause_in = rbts_pkg::ERR_LOW_VOLT;
                  end else if ((status_low & rbts_pkg::IMPULSE_BIT) != '0) begin
                     cause_in = rbts_pkg::ERR_IMPULSE;
                  end else begin
                     cause_in = rbts_pkg::ERR_GENERIC;
                  end
               end
               if (mode_in == rbts_pkg::MODE_WAIT_PLL) begin
                  if ((status_low & rbts_pkg::PLL_LOCK_BIT) == '0) begin
                     stop = 1'b1;
                  end else begin
                     rsp_in.calw = rbts_pkg::CALW_START;
                     mode_in     = rbts_pkg::MODE_CALIB;
                  end
               end
            end
            if (!stop && mode_in == rbts_pkg::MODE_CALIB) begin
               if (cal_status == '0) begin
                  stop = 1'b1;
               end else begin
                  rsp_in.calw = rbts_pkg::CALW_STOP;
                  mode_in     = rbts_pkg::MODE_READY;
               end
            end
            if (!stop) begin
               if (mode_in == rbts_pkg::MODE_TX_WAIT) begin
                  priority if ((status_low & rbts_pkg::TX_START_MASK) != '0) begin
                     mode_in    = rbts_pkg::MODE_TX_ACTIVE;
                     rsp_in.clr = rbts_pkg::TX_START_MASK;
                  end else if ((status_low & rbts_pkg::TX_LATE_BIT) != '0) begin
                     mode_in    = rbts_pkg::MODE_TX_LATE;
                     rsp_in.clr = rbts_pkg::TX_LATE_BIT;
                  end else if (radio_state == rbts_pkg::RSTATE_IDLE) begin
                     mode_in = rbts_pkg::MODE_TX_LATE;
                  end else begin
                     mode_in = rbts_pkg::MODE_TX_WAIT;
                  end
               end
               if (mode_in == rbts_pkg::MODE_TX_ACTIVE &&
                   (status_low & rbts_pkg::TX_DONE_BIT) != '0) begin
                  mode_in    = rbts_pkg::MODE_READY;
                  rsp_in.clr = rsp_in.clr | rbts_pkg::TX_DONE_BIT;
               end
            end
         end
         rbts_pkg::ACT_SCHEDULE: begin
            priority if (frame_size >= rbts_pkg::FRAME_SIZE_MAX) begin
               mode_in  = rbts_pkg::MODE_BUG;
               cause_in = rbts_pkg::ERR_BAD_SIZE;
            end else if (mode_ff != rbts_pkg::MODE_READY) begin
               mode_in  = rbts_pkg::MODE_BUG;
               cause_in = rbts_pkg::ERR_NOT_READY;
            end else begin
               rsp_in.cmd   = rbts_pkg::CMD_DELAY_TX;
               rsp_in.fctl  = rbts_pkg::FCTL_BASE | {3'd0, frame_size};
               rsp_in.stime = transmit_time;
               mode_in      = rbts_pkg::MODE_TX_WAIT;
            end
         end
         rbts_pkg::ACT_CANCEL: begin
            if (mode_ff >= rbts_pkg::MODE_READY && mode_ff <= rbts_pkg::MODE_TX_LATE) begin
               rsp_in.cmd = rbts_pkg::CMD_TRX_OFF;
               mode_in    = rbts_pkg::MODE_READY;
            end else begin
               mode_in  = rbts_pkg::MODE_BUG;
               cause_in = rbts_pkg::ERR_NOT_READY;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
      rsp_in.mode  = mode_in;
      rsp_in.cause = cause_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= rbts_pkg::MODE_INVALID;
         cause_ff     <= rbts_pkg::ERR_NONE;
         stamp_ff     <= '0;
         hold_ff      <= rbts_pkg::HOLD_MS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            hold_ff <= csr_data;
         end
         if (s1_valid_ff && advance) begin
            mode_ff  <= mode_in;
            cause_ff <= cause_in;
            stamp_ff <= stamp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
         s1_act_ff  <= req_tuser;
      end
      if (s1_valid_ff && advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.stime, rsp_ff.fctl, rsp_ff.cmd, rsp_ff.clr, rsp_ff.calw,
                        rsp_ff.setup, rsp_ff.drv, rsp_ff.cause, rsp_ff.mode};

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid_ff)
      else $error("staged item not moved to result register");

   a_delay_tx_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.cmd == rbts_pkg::CMD_DELAY_TX
      |-> rsp_ff.mode == rbts_pkg::MODE_TX_WAIT)
      else $error("delayed transmit without transmit-wait status");

   a_reset_pin_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.drv == rbts_pkg::DRV_LOW |-> rsp_ff.mode == rbts_pkg::MODE_RST)
      else $error("reset pin driven without reset status");

   a_bug_cause: assert property (@(posedge clock) disable iff (reset)
      mode_ff == rbts_pkg::MODE_BUG
      |-> cause_ff == rbts_pkg::ERR_BAD_SIZE || cause_ff == rbts_pkg::ERR_NOT_READY)
      else $error("code-bug status with a chip error cause");

endmodule

`default_nettype wire

// ===== verif/tx_sequencer_checker.sv =====
`timescale 1ns / 100ps
// tx_sequencer_checker: watches the csr, req and rsp channels of the sequencer core,
// predicts the host actions for every req transfer and compares each rsp transfer.
// Depends on rbts_pkg.
module tx_sequencer_checker
   import rbts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [7:0]            csr_data,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [ACTION_W-1:0]   req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                         outstanding,
   output int                         mismatches
);

   localparam int RSP_USED  = $bits(rsp_type);
   localparam int PRINT_CAP = 40;

   mode_type    mode_q;
   err_type     cause_q;
   logic [31:0] stamp_q;
   logic [7:0]  hold_q;

   rsp_type host_actions_due[$];
   rsp_type fresh;
   rsp_type due;
   rsp_type seen;

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t: rsp %s got 0x%0h, want 0x%0h", $realtime, field, got, want);
   endtask

   // One sequencer event: updates the tracked chip mode, error cause and reset stamp and returns the host actions.
   task automatic apply_event(input action_type act, input logic [REQ_DATA_W-1:0] d,
                              output rsp_type r);
      logic [31:0] now;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] cal;
      logic [31:0] rstate;
      logic [31:0] ttime;
      logic [31:0] elapsed;
      logic [9:0]  size;
      logic        irq;
      logic        halted;
      now    = d[31:0];
      irq    = d[32];
      lo     = d[64:33];
      hi     = d[96:65];
      cal    = d[128:97];
      rstate = d[160:129];
      size   = d[170:161];
      ttime  = d[202:171];
      r      = '0;
      halted = 1'b0;
      case (act)
         ACT_RESET: begin
            r.drv   = DRV_LOW;
            mode_q  = MODE_RST;
            stamp_q = now;
         end
         ACT_POLL: begin
            if (mode_q == MODE_RST) begin
               elapsed = now - stamp_q;
               if (elapsed < {24'd0, hold_q} || irq) begin
                  halted = 1'b1;
               end else begin
                  r.drv  = DRV_RELEASE;
                  mode_q = MODE_WAIT_IRQ;
               end
            end
            if (!halted && mode_q == MODE_WAIT_IRQ) begin
               if (!irq) begin
                  halted = 1'b1;
               end else begin
                  r.setup = 1'b1;
                  mode_q  = MODE_WAIT_PLL;
               end
            end
            if (!halted) begin
               // later causes win
               if ((lo & ERR_LO_MASK) != 0 || (hi & ERR_HI_MASK) != 0) begin
                  mode_q  = MODE_CHIP_ERR;
                  cause_q = ERR_GENERIC;
                  if ((lo & IMPULSE_BIT) != 0)     cause_q = ERR_IMPULSE;
                  if ((lo & LOW_VOLT_BIT) != 0)    cause_q = ERR_LOW_VOLT;
                  if ((lo & PLL_ERR_BIT) != 0)     cause_q = ERR_PLL;
                  if ((hi & CMD_ERR_HI_BIT) != 0)  cause_q = ERR_COMMAND;
                  if ((hi & SPI_ERR_HI_MASK) != 0) cause_q = ERR_SPI;
               end
               if (mode_q == MODE_WAIT_PLL) begin
                  if ((lo & PLL_LOCK_BIT) == 0) begin
                     halted = 1'b1;
                  end else begin
                     r.calw = CALW_START;
                     mode_q = MODE_CALIB;
                  end
               end
            end
            if (!halted && mode_q == MODE_CALIB) begin
               if (cal == 0) begin
                  halted = 1'b1;
               end else begin
                  r.calw = CALW_STOP;
                  mode_q = MODE_READY;
               end
            end
            if (!halted) begin
               if (mode_q == MODE_TX_WAIT) begin
                  if ((lo & TX_START_MASK) != 0) begin
                     mode_q = MODE_TX_ACTIVE;
                     r.clr |= TX_START_MASK;
                  end else if ((lo & TX_LATE_BIT) != 0) begin
                     mode_q = MODE_TX_LATE;
                     r.clr |= TX_LATE_BIT;
                  end else if (rstate == RSTATE_IDLE) begin
                     mode_q = MODE_TX_LATE;
                  end
               end
               if (mode_q == MODE_TX_ACTIVE && (lo & TX_DONE_BIT) != 0) begin
                  mode_q = MODE_READY;
                  r.clr |= TX_DONE_BIT;
               end
            end
         end
         ACT_SCHEDULE: begin
            if (size >= FRAME_SIZE_MAX) begin
               mode_q  = MODE_BUG;
               cause_q = ERR_BAD_SIZE;
            end else if (mode_q != MODE_READY) begin
               mode_q  = MODE_BUG;
               cause_q = ERR_NOT_READY;
            end else begin
               r.cmd   = CMD_DELAY_TX;
               r.fctl  = FCTL_BASE | 13'(size);
               r.stime = ttime;
               mode_q  = MODE_TX_WAIT;
            end
         end
         default: begin
            if (mode_q >= MODE_READY && mode_q <= MODE_TX_LATE) begin
               r.cmd  = CMD_TRX_OFF;
               mode_q = MODE_READY;
            end else begin
               mode_q  = MODE_BUG;
               cause_q = ERR_NOT_READY;
            end
         end
      endcase
      r.mode  = mode_q;
      r.cause = cause_q;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_q  = MODE_INVALID;
         cause_q = ERR_NONE;
         stamp_q = '0;
         hold_q  = HOLD_MS_RESET;
         host_actions_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            hold_q = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_type'(rsp_tdata[RSP_USED-1:0]);
            if (host_actions_due.size() == 0) begin
               report("transfer with nothing due, status", seen.mode, 0);
            end else begin
               due = host_actions_due.pop_front();
               if (seen.mode != due.mode)   report("status", seen.mode, due.mode);
               if (seen.cause != due.cause) report("error_kind", seen.cause, due.cause);
               if (seen.drv != due.drv)     report("drive_reset", seen.drv, due.drv);
               if (seen.setup != due.setup) report("chip_setup", seen.setup, due.setup);
               if (seen.calw != due.calw)   report("calibration_write", seen.calw, due.calw);
               if (seen.clr != due.clr)     report("clear_mask", seen.clr, due.clr);
               if (seen.cmd != due.cmd)     report("radio_command", seen.cmd, due.cmd);
               if (seen.fctl != due.fctl)   report("frame_control", seen.fctl, due.fctl);
               if (seen.stime != due.stime) report("scheduled_time", seen.stime, due.stime);
               if (rsp_tdata[RSP_DATA_W-1:RSP_USED] != 0)
                  report("pad", rsp_tdata[RSP_DATA_W-1:RSP_USED], 0);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_event(action_type'(req_tuser), req_tdata, fresh);
            host_actions_due.push_back(fresh);
         end
      end
      outstanding <= host_actions_due.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: stimulus for radio_bringup_tx_sequencer_core - directed bring-up and transmit
// sequences, then random sessions across hold-time settings. Uses tx_sequencer_checker.
module tb;
   import rbts_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 4;

   typedef struct {
      action_type  act;
      logic [31:0] now;
      logic        irq;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] cal;
      logic [31:0] rstate;
      logic [9:0]  size;
      logic [31:0] ttime;
   } radio_event_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [7:0]            csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [ACTION_W-1:0]   req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    outstanding;
   int                    mismatches;

   int          items_sent  = 0;
   int          burst_left  = 0;
   int          holds_asked = 0;
   int          holds_done  = 0;
   int          hold_ms     = int'(HOLD_MS_RESET);
   logic [31:0] ms_now      = '0;

   radio_bringup_tx_sequencer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tx_sequencer_checker sequencer_check (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic bit chance(input int n);
      return $urandom_range(0, n - 1) == 0;
   endfunction

   function automatic radio_event_type quiet_event(input action_type a);
      radio_event_type e;
      e.act    = a;
      e.now    = ms_now;
      e.irq    = 1'b0;
      e.lo     = '0;
      e.hi     = '0;
      e.cal    = '0;
      e.rstate = '0;
      e.size   = '0;
      e.ttime  = '0;
      return e;
   endfunction

   // status words with mostly harmless content; chip errors are rare
   function automatic radio_event_type poll_event(input bit tx_stage);
      radio_event_type e;
      logic [31:0]     w;
      e = quiet_event(ACT_POLL);
      w = '0;
      if (chance(4))
         w = $urandom & ~(ERR_LO_MASK | PLL_LOCK_BIT | TX_START_MASK | TX_LATE_BIT);
      if (tx_stage) begin
         e.irq = 1'($urandom_range(0, 1));
         if (chance(2)) w |= TX_START_MASK & $urandom;
         if (chance(2)) w |= TX_DONE_BIT;
         if (chance(6)) w |= TX_LATE_BIT;
         if (chance(2)) w |= PLL_LOCK_BIT;
      end else begin
         e.irq = !chance(4);
         if (chance(2)) w |= PLL_LOCK_BIT;
      end
      if (chance(30)) w |= ERR_LO_MASK & $urandom;
      if (chance(40)) w = $urandom;
      e.lo = w;
      if (chance(3)) e.hi = $urandom & ~ERR_HI_MASK;
      if (chance(30)) e.hi |= ERR_HI_MASK & $urandom;
      if (chance(2)) e.cal = $urandom | (32'h1 << $urandom_range(0, 31));
      e.rstate = chance(6) ? RSTATE_IDLE : $urandom;
      return e;
   endfunction

   task automatic offer(input radio_event_type e);
      int gap;
      if (burst_left == 0) begin
         gap = chance(4) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= e.act;
      req_tdata  <= {5'd0, e.ttime, e.size, e.rstate, e.cal, e.hi, e.lo, e.irq, e.now};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // lets every outstanding result arrive before a csr write or the verdict
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_hold(input int value);
      hold_ms = value;
      csr_valid <= 1'b1;
      csr_data  <= value[7:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic directed();
      radio_event_type e;
      e = quiet_event(ACT_POLL);                     // poll before any reset
      offer(e);
      e = quiet_event(ACT_CANCEL);                   // cancel outside ready..late
      offer(e);
      e = quiet_event(ACT_SCHEDULE);                 // schedule when not ready
      e.size = 10'd5;
      offer(e);
      e.size = 10'd1023;                             // bad size
      offer(e);
      e.size = FRAME_SIZE_MAX;
      offer(e);
      ms_now = 32'hFFFF_FFFA;
      e = quiet_event(ACT_RESET);
      offer(e);
      e = quiet_event(ACT_POLL);                     // 9 ms across the wrap
      e.now = 32'h3;
      offer(e);
      e.now = 32'h4;                                 // hold met, irq still high
      e.irq = 1'b1;
      offer(e);
      e.irq = 1'b0;                                  // release
      offer(e);
      e.irq = 1'b1;                                  // lock and cal in one poll
      e.lo  = PLL_LOCK_BIT;
      e.cal = '1;
      offer(e);
      e = quiet_event(ACT_SCHEDULE);
      e.size  = 10'd1020;
      e.ttime = '1;
      offer(e);
      e = quiet_event(ACT_POLL);                     // start and done together
      e.lo = 32'h0000_0090;
      offer(e);
      e = quiet_event(ACT_SCHEDULE);
      offer(e);
      e = quiet_event(ACT_POLL);
      e.lo = TX_LATE_BIT;
      offer(e);
      e = quiet_event(ACT_CANCEL);
      offer(e);
      e = quiet_event(ACT_SCHEDULE);
      offer(e);
      e = quiet_event(ACT_POLL);                     // idle state after a missed slot
      e.rstate = RSTATE_IDLE;
      offer(e);
      e = quiet_event(ACT_CANCEL);
      offer(e);
      e = quiet_event(ACT_POLL);                     // every error bit, spi wins
      e.lo = ERR_LO_MASK;
      e.hi = ERR_HI_MASK;
      offer(e);
      e.hi = '0;
      offer(e);
      e.lo = IMPULSE_BIT;
      offer(e);
      e.lo = LOW_VOLT_BIT;
      offer(e);
      e.lo = '0;
      e.hi = CMD_ERR_HI_BIT;
      offer(e);
      e = quiet_event(ACT_RESET);                    // cause survives reset
      offer(e);
      e = quiet_event(ACT_CANCEL);
      offer(e);
   endtask

   task automatic bring_up_session();
      radio_event_type e;
      logic [31:0]     stamp;
      if (chance(6)) ms_now = $urandom;
      else ms_now += $urandom_range(0, 50);
      stamp = ms_now;
      e = quiet_event(ACT_RESET);
      offer(e);
      if (hold_ms != 0) begin
         repeat ($urandom_range(0, 3)) begin
            e = poll_event(1'b0);
            e.now = stamp + $urandom_range(0, hold_ms - 1);
            e.irq = 1'($urandom_range(0, 1));
            offer(e);
         end
      end
      ms_now = stamp + 32'(hold_ms) + $urandom_range(0, 3);
      e = poll_event(1'b0);
      e.irq = chance(6);
      offer(e);
      repeat ($urandom_range(2, 7)) begin
         ms_now += $urandom_range(0, 3);
         e = poll_event(1'b0);
         offer(e);
      end
      repeat ($urandom_range(1, 6)) begin
         e = quiet_event(ACT_SCHEDULE);
         e.size  = chance(10) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 1020));
         e.ttime = $urandom;
         offer(e);
         repeat ($urandom_range(1, 4)) begin
            ms_now += $urandom_range(0, 3);
            e = poll_event(1'b1);
            offer(e);
         end
         if (chance(2)) begin
            e = quiet_event(ACT_CANCEL);
            offer(e);
         end
      end
   endtask

   task automatic noise_burst();
      radio_event_type e;
      repeat ($urandom_range(1, 5)) begin
         e.act    = action_type'(2'($urandom_range(0, 3)));
         e.now    = chance(2) ? ms_now : $urandom;
         e.irq    = 1'($urandom_range(0, 1));
         e.lo     = $urandom;
         e.hi     = $urandom;
         e.cal    = $urandom;
         e.rstate = $urandom;
         e.size   = 10'($urandom_range(0, 1023));
         e.ttime  = $urandom;
         offer(e);
      end
   endtask

   task automatic random_phase(input int n);
      int target;
      target = items_sent + n;
      while (items_sent < target) begin
         if (chance(7)) noise_burst();
         else bring_up_session();
      end
   endtask

   // receiver: stall pattern of its own, plus long hold-offs on request
   initial begin
      int style;
      int style_left;
      style      = 0;
      style_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (style_left == 0) begin
               style      = $urandom_range(0, 3);
               style_left = $urandom_range(16, 200);
            end
            style_left--;
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= !chance(8);
               2: rsp_tready <= chance(2);
               default: rsp_tready <= chance(4);
            endcase
         end
      end
   end

   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck = 0;
         else stuck++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int settings[5];
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      settings   = '{0, 255, $urandom_range(2, 254), 1, $urandom_range(2, 254)};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      directed();
      drain();
      foreach (settings[i]) begin
         write_hold(settings[i]);
         if (i == 1 || i == 3) holds_asked++;
         random_phase(250);
         drain();
      end
      if (mismatches == 0 && outstanding == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rbts_pkg.sv
hdl/radio_bringup_tx_sequencer_core.sv
verif/tx_sequencer_checker.sv
verif/tb.sv
